### rtl/core/tgcb_pkg.sv
// ----------------------------------------------------------------------------
// tgcb_pkg
// Shared widths, register codes and types for the triangle grid cell binning
// block.
// ----------------------------------------------------------------------------
package tgcb_pkg;

    localparam int COUNT_BITS = 10;
    localparam int COORD_BITS = 32;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int INV_W      = 32;
    localparam int FRAC_SHIFT = 32;
    localparam int CELL_W     = 10;
    localparam int INDEX_W    = 30;
    localparam int GRID_W     = 3 * COUNT_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = COORD_BITS + INV_W;
    localparam int PIPE_DEPTH = 6;

    localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(65536);
    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(1)
                                             | (GRID_W'(1) << COUNT_BITS)
                                             | (GRID_W'(1) << (2 * COUNT_BITS));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_INV_CELL_X = 3'd3,
        REG_INV_CELL_Y = 3'd4,
        REG_INV_CELL_Z = 3'd5,
        REG_GRID_COUNT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                  fit;
        logic [COUNT_BITS-1:0] cell_idx;
    } cell_map_t;

endpackage

### rtl/core/tgcb_coord_map.sv
// ----------------------------------------------------------------------------
// tgcb_coord_map
// One coordinate lane: offset from the grid origin, then scale by the inverse
// cell width and keep the integer part as the cell index. Two register stages.
// ----------------------------------------------------------------------------
module tgcb_coord_map (
    input  logic                                clk,
    input  logic [tgcb_pkg::COORD_BITS-1:0]     coord,
    input  logic [tgcb_pkg::COORD_BITS-1:0]     origin,
    input  logic [tgcb_pkg::INV_W-1:0]          inv,
    output tgcb_pkg::cell_map_t                 map
);
    import tgcb_pkg::*;

    logic [DIFF_W-1:0]     diff;
    logic                  neg_reg;
    logic [COORD_BITS-1:0] mag_reg;
    logic [PROD_W-1:0]     prod;
    cell_map_t             map_reg;
    cell_map_t             map_next;

    assign diff = {coord[COORD_BITS-1], coord} - {origin[COORD_BITS-1], origin};

    always_ff @(posedge clk)
    begin
        neg_reg <= diff[DIFF_W-1];
        mag_reg <= diff[COORD_BITS-1:0];
    end

    assign prod = PROD_W'(mag_reg) * PROD_W'(inv);

    always_comb
    begin
        map_next.fit      = !neg_reg && (prod[PROD_W-1:FRAC_SHIFT+COUNT_BITS] == '0);
        map_next.cell_idx = prod[FRAC_SHIFT +: COUNT_BITS];
    end

    always_ff @(posedge clk)
    begin
        map_reg <= map_next;
    end

    assign map = map_reg;

endmodule

### rtl/core/triangle_grid_cell_binning.sv
// ----------------------------------------------------------------------------
// triangle_grid_cell_binning
// Maps a triangle to the cell bounding box it covers in a uniform 3-D grid.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive v0_x..v2_z and pulse start. A request is taken at
//   every rising edge where start is high and busy is low; busy stays low, so
//   one triangle can be taken every cycle.
//   Result channel: done is high for exactly one cycle with in_grid, the
//   bounding box and first_cell_index. The result is taken at the edge that
//   ends that cycle; the receiver cannot stall it. Results come back in
//   request order.
//   Stages: input register, offset, multiply, range check and box, index
//   products, output register; done comes out with the output register.
//   Throughput: one triangle per cycle, set by the nine parallel coordinate
//   lanes, each with one 32x32 multiply.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while no request is in flight.
//   Reset: clears the pipeline valid bits and done, and restores the
//   registers (origin 0, inverse cell 1.0, one cell per axis).
// ----------------------------------------------------------------------------
module triangle_grid_cell_binning (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v0_x,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v0_y,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v0_z,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v1_x,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v1_y,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v1_z,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v2_x,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v2_y,
    input  logic signed [tgcb_pkg::COORD_BITS-1:0]  v2_z,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tgcb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tgcb_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic                                    done,
    output logic                                    in_grid,
    output logic [tgcb_pkg::CELL_W-1:0]             cell_x_min,
    output logic [tgcb_pkg::CELL_W-1:0]             cell_x_max,
    output logic [tgcb_pkg::CELL_W-1:0]             cell_y_min,
    output logic [tgcb_pkg::CELL_W-1:0]             cell_y_max,
    output logic [tgcb_pkg::CELL_W-1:0]             cell_z_min,
    output logic [tgcb_pkg::CELL_W-1:0]             cell_z_max,
    output logic [tgcb_pkg::INDEX_W-1:0]            first_cell_index
);
    import tgcb_pkg::*;

    logic                  accept;
    logic [PIPE_DEPTH-1:0] vld_reg;

    logic [CFG_DATA_W-1:0] origin_reg [3];
    logic [INV_W-1:0]      inv_reg [3];
    logic [GRID_W-1:0]     grid_counts_reg;
    logic [INDEX_W-1:0]    cnt01_reg;
    logic [GRID_W-1:0]     grid_wr;

    logic [COORD_BITS-1:0] org_ext [3];
    logic [COUNT_BITS-1:0] cnt [3];

    logic [COORD_BITS-1:0] vtx_in [9];
    logic [COORD_BITS-1:0] vtx_reg [9];
    cell_map_t             map [9];

    logic                  ok4_next;
    logic [COUNT_BITS-1:0] lo4_next [3];
    logic [COUNT_BITS-1:0] hi4_next [3];
    logic                  ok4_reg;
    logic [COUNT_BITS-1:0] lo4_reg [3];
    logic [COUNT_BITS-1:0] hi4_reg [3];

    logic                  ok5_reg;
    logic [COUNT_BITS-1:0] lo5_reg [3];
    logic [COUNT_BITS-1:0] hi5_reg [3];
    logic [INDEX_W-1:0]    part_x_reg;
    logic [INDEX_W-1:0]    part_y_reg;
    logic [INDEX_W-1:0]    part_z_reg;

    logic                  in_grid_reg;
    logic [CELL_W-1:0]     lo_out_reg [3];
    logic [CELL_W-1:0]     hi_out_reg [3];
    logic [INDEX_W-1:0]    index_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    assign grid_wr = GRID_W'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                origin_reg[a] <= '0;
                inv_reg[a]    <= INV_RESET;
            end
            grid_counts_reg <= GRID_RESET;
            cnt01_reg       <= INDEX_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIGIN_X:   origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:   origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:   origin_reg[2] <= cfg_data;
                REG_INV_CELL_X: inv_reg[0]    <= INV_W'(cfg_data);
                REG_INV_CELL_Y: inv_reg[1]    <= INV_W'(cfg_data);
                REG_INV_CELL_Z: inv_reg[2]    <= INV_W'(cfg_data);
                REG_GRID_COUNT:
                begin
                    grid_counts_reg <= grid_wr;
                    cnt01_reg       <= INDEX_W'(grid_wr[COUNT_BITS-1:0])
                                     * INDEX_W'(grid_wr[COUNT_BITS +: COUNT_BITS]);
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            org_ext[a] = COORD_BITS'(origin_reg[a]);
            cnt[a]     = grid_counts_reg[a*COUNT_BITS +: COUNT_BITS];
        end
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // input register
    assign vtx_in[0] = v0_x;
    assign vtx_in[1] = v0_y;
    assign vtx_in[2] = v0_z;
    assign vtx_in[3] = v1_x;
    assign vtx_in[4] = v1_y;
    assign vtx_in[5] = v1_z;
    assign vtx_in[6] = v2_x;
    assign vtx_in[7] = v2_y;
    assign vtx_in[8] = v2_z;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 9; i++)
            begin
                vtx_reg[i] <= vtx_in[i];
            end
        end
    end

    // coordinate lanes, index v*3 + axis
    for (genvar v = 0; v < 3; v++)
    begin : g_vtx
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            tgcb_coord_map u_map (
                .clk    (clk),
                .coord  (vtx_reg[v*3+a]),
                .origin (org_ext[a]),
                .inv    (inv_reg[a]),
                .map    (map[v*3+a])
            );
        end
    end

    // range check and bounding box
    always_comb
    begin
        ok4_next = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                if (!map[v*3+a].fit || !(map[v*3+a].cell_idx < cnt[a]))
                begin
                    ok4_next = 1'b0;
                end
            end
            lo4_next[a] = map[a].cell_idx;
            hi4_next[a] = map[a].cell_idx;
            for (int v = 1; v < 3; v++)
            begin
                if (map[v*3+a].cell_idx < lo4_next[a])
                begin
                    lo4_next[a] = map[v*3+a].cell_idx;
                end
                if (map[v*3+a].cell_idx > hi4_next[a])
                begin
                    hi4_next[a] = map[v*3+a].cell_idx;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok4_reg <= ok4_next;
        lo4_reg <= lo4_next;
        hi4_reg <= hi4_next;
    end

    // linear index products
    always_ff @(posedge clk)
    begin
        ok5_reg    <= ok4_reg;
        lo5_reg    <= lo4_reg;
        hi5_reg    <= hi4_reg;
        part_x_reg <= INDEX_W'(lo4_reg[0]);
        part_y_reg <= INDEX_W'(lo4_reg[1]) * INDEX_W'(cnt[0]);
        part_z_reg <= INDEX_W'(lo4_reg[2]) * cnt01_reg;
    end

    // result register; a triangle off the grid reports all zeros
    always_ff @(posedge clk)
    begin
        in_grid_reg <= ok5_reg;
        for (int a = 0; a < 3; a++)
        begin
            lo_out_reg[a] <= ok5_reg ? CELL_W'(lo5_reg[a]) : '0;
            hi_out_reg[a] <= ok5_reg ? CELL_W'(hi5_reg[a]) : '0;
        end
        index_reg <= ok5_reg ? (part_x_reg + part_y_reg + part_z_reg) : '0;
    end

    assign done             = vld_reg[PIPE_DEPTH-1];
    assign in_grid          = in_grid_reg;
    assign cell_x_min       = lo_out_reg[0];
    assign cell_x_max       = hi_out_reg[0];
    assign cell_y_min       = lo_out_reg[1];
    assign cell_y_max       = hi_out_reg[1];
    assign cell_z_min       = lo_out_reg[2];
    assign cell_z_max       = hi_out_reg[2];
    assign first_cell_index = index_reg;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##6 done)
        else $error("result strobe missing after request");

    a_off_grid_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_grid |-> first_cell_index == '0 && cell_x_max == '0
                             && cell_y_max == '0 && cell_z_max == '0)
        else $error("off-grid result carries nonzero fields");

    a_box_order : assert property (@(posedge clk) disable iff (!rst_n)
        done && in_grid |-> cell_x_min <= cell_x_max && cell_y_min <= cell_y_max
                            && cell_z_min <= cell_z_max)
        else $error("bounding box min above max");
`endif

endmodule

### test/cell_bin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_bin_checker
// Watches the request, result and register channels of the triangle grid
// cell binning block, predicts each result from its own copy of the grid
// registers and compares it field by field, in order, with what comes out.
// ----------------------------------------------------------------------------
module cell_bin_checker (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic                                        busy,
    input  logic [8:0][tgcb_pkg::COORD_BITS-1:0]        vtx,
    input  logic                                        cfg_valid,
    input  logic                                        cfg_ready,
    input  logic [tgcb_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [tgcb_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  logic                                        done,
    input  logic                                        in_grid,
    input  logic [tgcb_pkg::CELL_W-1:0]                 cell_x_min,
    input  logic [tgcb_pkg::CELL_W-1:0]                 cell_x_max,
    input  logic [tgcb_pkg::CELL_W-1:0]                 cell_y_min,
    input  logic [tgcb_pkg::CELL_W-1:0]                 cell_y_max,
    input  logic [tgcb_pkg::CELL_W-1:0]                 cell_z_min,
    input  logic [tgcb_pkg::CELL_W-1:0]                 cell_z_max,
    input  logic [tgcb_pkg::INDEX_W-1:0]                first_cell_index,
    output int                                          errors,
    output int                                          pending
);
    import tgcb_pkg::*;

    typedef struct packed {
        logic                in_grid;
        logic [CELL_W-1:0]   x_min;
        logic [CELL_W-1:0]   x_max;
        logic [CELL_W-1:0]   y_min;
        logic [CELL_W-1:0]   y_max;
        logic [CELL_W-1:0]   z_min;
        logic [CELL_W-1:0]   z_max;
        logic [INDEX_W-1:0]  first;
    } bin_result_t;

    logic [31:0]       grid_org [3];
    logic [INV_W-1:0]  grid_inv [3];
    logic [GRID_W-1:0] grid_cnt;
    bin_result_t       expected_bins [$];
    int                miss = 0;

    function automatic cell_map_t axis_cell(input logic [31:0] coord, input logic [31:0] org,
                                            input logic [INV_W-1:0] inv,
                                            input logic [COUNT_BITS-1:0] cnt);
        cell_map_t   m;
        logic [32:0] diff;
        logic [63:0] prod;
        logic [31:0] idx;
        diff = {coord[31], coord} - {org[31], org};
        prod = {32'b0, diff[31:0]} * {32'b0, inv};
        idx = prod[63:32];
        m.cell_idx = idx[COUNT_BITS-1:0];
        m.fit = !diff[32] && (idx < {22'b0, cnt});
        return m;
    endfunction

    function automatic bin_result_t bin_triangle(input logic [8:0][31:0] t);
        bin_result_t           r;
        cell_map_t             m;
        logic [COUNT_BITS-1:0] lo [3];
        logic [COUNT_BITS-1:0] hi [3];
        logic [COUNT_BITS-1:0] cnt [3];
        logic                  ok;
        logic [63:0]           idx;
        cnt[0] = grid_cnt[COUNT_BITS-1:0];
        cnt[1] = grid_cnt[2*COUNT_BITS-1:COUNT_BITS];
        cnt[2] = grid_cnt[3*COUNT_BITS-1:2*COUNT_BITS];
        ok = 1'b1;
        r = '0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = '0;
            hi[a] = '0;
        end
        for (int v = 0; v < 3; v++) begin
            for (int a = 0; a < 3; a++) begin
                m = axis_cell(t[v*3+a], grid_org[a], grid_inv[a], cnt[a]);
                if (!m.fit) begin
                    ok = 1'b0;
                end else if (v == 0) begin
                    lo[a] = m.cell_idx;
                    hi[a] = m.cell_idx;
                end else begin
                    if (m.cell_idx < lo[a]) lo[a] = m.cell_idx;
                    if (m.cell_idx > hi[a]) hi[a] = m.cell_idx;
                end
            end
        end
        if (ok) begin
            idx = 64'(lo[0]) + 64'(lo[1]) * 64'(cnt[0]) + 64'(lo[2]) * 64'(cnt[0]) * 64'(cnt[1]);
            r.in_grid = 1'b1;
            r.x_min = lo[0];
            r.x_max = hi[0];
            r.y_min = lo[1];
            r.y_max = hi[1];
            r.z_min = lo[2];
            r.z_max = hi[2];
            r.first = idx[INDEX_W-1:0];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [INDEX_W-1:0] want,
                               input logic [INDEX_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            miss++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        bin_result_t want;
        if (!rst_n) begin
            for (int a = 0; a < 3; a++) begin
                grid_org[a] = '0;
                grid_inv[a] = INV_RESET;
            end
            grid_cnt = GRID_RESET;
            expected_bins.delete();
        end else begin
            if (done) begin
                if (expected_bins.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none actual %0h",
                             $time, first_cell_index);
                    miss++;
                end else begin
                    want = expected_bins.pop_front();
                    check_field("in_grid", INDEX_W'(want.in_grid), INDEX_W'(in_grid));
                    check_field("cell_x_min", INDEX_W'(want.x_min), INDEX_W'(cell_x_min));
                    check_field("cell_x_max", INDEX_W'(want.x_max), INDEX_W'(cell_x_max));
                    check_field("cell_y_min", INDEX_W'(want.y_min), INDEX_W'(cell_y_min));
                    check_field("cell_y_max", INDEX_W'(want.y_max), INDEX_W'(cell_y_max));
                    check_field("cell_z_min", INDEX_W'(want.z_min), INDEX_W'(cell_z_min));
                    check_field("cell_z_max", INDEX_W'(want.z_max), INDEX_W'(cell_z_max));
                    check_field("first_cell_index", want.first, first_cell_index);
                end
            end
            if (start && !busy)
                expected_bins.insert(expected_bins.size(), bin_triangle(vtx));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ORIGIN_X:   grid_org[0] = cfg_data;
                    REG_ORIGIN_Y:   grid_org[1] = cfg_data;
                    REG_ORIGIN_Z:   grid_org[2] = cfg_data;
                    REG_INV_CELL_X: grid_inv[0] = cfg_data;
                    REG_INV_CELL_Y: grid_inv[1] = cfg_data;
                    REG_INV_CELL_Z: grid_inv[2] = cfg_data;
                    REG_GRID_COUNT: grid_cnt = cfg_data[GRID_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= expected_bins.size();
        errors <= miss;
    end

endmodule

### test/triangle_grid_cell_binning_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_grid_cell_binning_tb
// Drives triangles and grid register writes into the binning block: a directed
// pass over origin, cell width and cell count extremes, then randomized grids
// with mostly in-grid triangles, random request gaps and drained phase ends.
// ----------------------------------------------------------------------------
module triangle_grid_cell_binning_tb;
    import tgcb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef logic [8:0][COORD_BITS-1:0] triangle_t;
    typedef logic [2:0][COORD_BITS-1:0] vertex_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    triangle_t              vtx;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    logic                   in_grid;
    logic [CELL_W-1:0]      cell_x_min;
    logic [CELL_W-1:0]      cell_x_max;
    logic [CELL_W-1:0]      cell_y_min;
    logic [CELL_W-1:0]      cell_y_max;
    logic [CELL_W-1:0]      cell_z_min;
    logic [CELL_W-1:0]      cell_z_max;
    logic [INDEX_W-1:0]     first_cell_index;
    int                     errors;
    int                     pending;
    int                     stall_cycles = 0;
    bit                     idle_on;

    logic [31:0]            cur_org [3];
    logic [31:0]            cur_inv [3];
    logic [COUNT_BITS-1:0]  cur_cnt [3];

    triangle_grid_cell_binning dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .v0_x(vtx[0]), .v0_y(vtx[1]), .v0_z(vtx[2]),
        .v1_x(vtx[3]), .v1_y(vtx[4]), .v1_z(vtx[5]),
        .v2_x(vtx[6]), .v2_y(vtx[7]), .v2_z(vtx[8]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .in_grid(in_grid),
        .cell_x_min(cell_x_min), .cell_x_max(cell_x_max),
        .cell_y_min(cell_y_min), .cell_y_max(cell_y_max),
        .cell_z_min(cell_z_min), .cell_z_max(cell_z_max),
        .first_cell_index(first_cell_index)
    );

    cell_bin_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .vtx(vtx),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .in_grid(in_grid),
        .cell_x_min(cell_x_min), .cell_x_max(cell_x_max),
        .cell_y_min(cell_y_min), .cell_y_max(cell_y_max),
        .cell_z_min(cell_z_min), .cell_z_max(cell_z_max),
        .first_cell_index(first_cell_index), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic vertex_t vert(input logic [31:0] base, input logic [31:0] dx,
                                     input logic [31:0] dy, input logic [31:0] dz);
        return {base + dz, base + dy, base + dx};
    endfunction

    // mode 0: inside the grid span, 1: slightly past it, 2: any value
    function automatic logic [31:0] pick_coord(input int a, input int mode);
        longint o;
        longint span;
        longint lim;
        longint r;
        if (mode == 2) return $urandom;
        o = longint'($signed(cur_org[a]));
        lim = 64'sd2147483647 - o + 1;
        if (cur_inv[a] == 0)
            span = lim;
        else
            span = longint'(({32'b0, 22'b0, cur_cnt[a]} << 32) / {32'b0, cur_inv[a]});
        if (span > lim) span = lim;
        if (mode == 1) span = span + span / 4 + 2;
        if (span < 1) span = 1;
        r = longint'({$urandom, $urandom} >> 1);
        return 32'(o + r % span);
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t t;
        int        kind;
        int        bad;
        kind = $urandom_range(99);
        bad = (kind < 70) ? -1 : $urandom_range(8);
        for (int i = 0; i < 9; i++) begin
            if (kind >= 90)
                t[i] = pick_coord(i % 3, 2);
            else if (i == bad)
                t[i] = pick_coord(i % 3, $urandom_range(1, 2));
            else
                t[i] = pick_coord(i % 3, 0);
        end
        return t;
    endfunction

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] d);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data = d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] ix,
                            input logic [31:0] iy, input logic [31:0] iz,
                            input logic [31:0] counts);
        drain();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_CELL_X, ix);
        write_reg(REG_INV_CELL_Y, iy);
        write_reg(REG_INV_CELL_Z, iz);
        write_reg(REG_GRID_COUNT, counts);
        cur_org[0] = ox;
        cur_org[1] = oy;
        cur_org[2] = oz;
        cur_inv[0] = ix;
        cur_inv[1] = iy;
        cur_inv[2] = iz;
        cur_cnt[0] = counts[9:0];
        cur_cnt[1] = counts[19:10];
        cur_cnt[2] = counts[29:20];
    endtask

    task automatic random_grid();
        logic [31:0] org [3];
        logic [31:0] inv [3];
        logic [9:0]  cnt [3];
        int          k;
        for (int a = 0; a < 3; a++) begin
            k = $urandom_range(9);
            if (k == 0)
                org[a] = 32'h8000_0000;
            else if (k == 1)
                org[a] = 32'h7FFF_FFFF;
            else
                org[a] = 32'($signed($urandom) >>> 1);
            k = $urandom_range(9);
            if (k == 0)
                inv[a] = '0;
            else if (k == 1)
                inv[a] = 32'hFFFF_FFFF;
            else if (k < 5)
                inv[a] = $urandom;
            else
                inv[a] = $urandom_range(1 << 12, 1 << 20);
            k = $urandom_range(19);
            if (k == 0)
                cnt[a] = '0;
            else if (k < 3)
                cnt[a] = 10'h3FF;
            else
                cnt[a] = 10'($urandom_range(1, 16));
        end
        set_grid(org[0], org[1], org[2], inv[0], inv[1], inv[2],
                 {2'($urandom), cnt[2], cnt[1], cnt[0]});
    endtask

    task automatic send_tri(input triangle_t t);
        if (idle_on) begin
            while ($urandom_range(99) < 25) begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        start = 1'b1;
        vtx = t;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        vtx = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        idle_on = 1'b0;
        for (int a = 0; a < 3; a++) begin
            cur_org[a] = '0;
            cur_inv[a] = INV_RESET;
            cur_cnt[a] = 10'd1;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset grid: one unit cell at the origin
        send_tri({vert(0, 0, 0, 0), vert(0, 0, 0, 0), vert(0, 0, 0, 0)});
        send_tri({vert(32'hFFFF, 0, 0, 0), vert(32'hFFFF, 0, 0, 0), vert(32'hFFFF, 0, 0, 0)});
        send_tri({vert(0, 0, 0, 0), vert(0, 32'h1_0000, 0, 0), vert(0, 0, 0, 0)});
        send_tri({vert(0, 0, 0, 32'hFFFF_FFFF), vert(0, 0, 0, 0), vert(0, 0, 0, 0)});
        send_tri({vert(0, 0, 0, 0), vert(0, 0, 0, 0), vert(0, 0, 32'h7FFF_FFFF, 0)});
        send_tri({vert(0, 0, 0, 0), vert(0, 0, 0, 32'h8000_0000), vert(0, 0, 0, 0)});

        // flat axes over the full coordinate range
        set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 32'h3FFF_FFFF);
        send_tri({vert(32'h8000_0000, 0, 0, 0), vert(32'h8000_0000, 0, 0, 0),
                  vert(32'h8000_0000, 0, 0, 0)});
        send_tri({vert(32'h7FFF_FFFF, 0, 0, 0), vert(32'h7FFF_FFFF, 0, 0, 0),
                  vert(32'h7FFF_FFFF, 0, 0, 0)});
        send_tri({vert(0, 0, 32'h7FFF_FFFF, 32'h8000_0000), vert(32'h8000_0000, 0, 0, 0),
                  vert(32'h7FFF_FFFF, 0, 0, 0)});

        // largest inverse width and largest counts
        set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tri({vert(32'h8000_0000, 0, 1, 1023), vert(32'h8000_0000, 1, 1023, 0),
                  vert(32'h8000_0000, 1023, 0, 1)});
        send_tri({vert(32'h8000_0000, 1023, 1023, 1023), vert(32'h8000_0000, 1023, 1023, 1023),
                  vert(32'h8000_0000, 1023, 1023, 1023)});
        send_tri({vert(32'h8000_0000, 1, 900, 4), vert(32'h8000_0000, 700, 5, 1000),
                  vert(32'h8000_0000, 2, 3, 500)});
        send_tri({vert(32'h8000_0000, 0, 0, 0), vert(32'h8000_0000, 1024, 0, 0),
                  vert(32'h8000_0000, 0, 0, 0)});
        send_tri({vert(32'h8000_0000, 0, 0, 1024), vert(32'h8000_0000, 0, 0, 0),
                  vert(32'h8000_0000, 0, 0, 0)});

        // origin at the top of the range
        set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, INV_RESET, INV_RESET,
                 INV_RESET, 32'h0010_0401);
        send_tri({vert(32'h7FFF_FFFF, 0, 0, 0), vert(32'h7FFF_FFFF, 0, 0, 0),
                  vert(32'h7FFF_FFFF, 0, 0, 0)});
        send_tri({vert(32'h7FFF_FFFF, 0, 0, 0), vert(32'h7FFF_FFFE, 0, 0, 0),
                  vert(32'h7FFF_FFFF, 0, 0, 0)});

        // zero cell count on one axis, then on all axes
        set_grid(0, 0, 0, INV_RESET, INV_RESET, INV_RESET, {2'b00, 10'd0, 10'd4, 10'd4});
        send_tri({vert(0, 0, 0, 0), vert(0, 0, 0, 0), vert(0, 0, 0, 0)});
        set_grid(0, 0, 0, INV_RESET, INV_RESET, INV_RESET, 32'h0000_0000);
        send_tri({vert(32'h1234, 0, 0, 0), vert(0, 0, 0, 0), vert(0, 0, 0, 0)});

        for (int p = 0; p < 8; p++) begin
            random_grid();
            idle_on = (p != 3);
            repeat (50) send_tri(random_triangle());
        end
        drain();

        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/core/tgcb_pkg.sv
rtl/core/tgcb_coord_map.sv
rtl/core/triangle_grid_cell_binning.sv
test/cell_bin_checker.sv
test/triangle_grid_cell_binning_tb.sv
